/* design/bpe_pkg.sv */
// Shared types and constants for the bit-plane extract/pack block.
// Holds the request/response payload structs, CSR indexes and the raster op codes.
// No dependencies.
`timescale 1ns / 1ps

package bpe_pkg;

   localparam int WORD_BITS  = 32;
   localparam int POS_BITS   = $clog2(WORD_BITS);
   localparam int PIXEL_BITS = 8;
   localparam int PLANE_BITS = $clog2(PIXEL_BITS);
   localparam int ROP_BITS   = 4;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [POS_BITS-1:0]  pos_type;

   // CSR indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RASTER_OP    = 4'd0,
      CSR_PLANE_SELECT = 4'd1,
      CSR_PLANE_ENABLE = 4'd2,
      CSR_MSB_FIRST    = 4'd3
   } csr_index_type;

   // Standard X raster op codes
   typedef enum logic [ROP_BITS-1:0] {
      ROP_CLEAR         = 4'd0,
      ROP_AND           = 4'd1,
      ROP_AND_REVERSE   = 4'd2,
      ROP_COPY          = 4'd3,
      ROP_AND_INVERTED  = 4'd4,
      ROP_NOOP          = 4'd5,
      ROP_XOR           = 4'd6,
      ROP_OR            = 4'd7,
      ROP_NOR           = 4'd8,
      ROP_EQUIV         = 4'd9,
      ROP_INVERT        = 4'd10,
      ROP_OR_REVERSE    = 4'd11,
      ROP_COPY_INVERTED = 4'd12,
      ROP_OR_INVERTED   = 4'd13,
      ROP_NAND          = 4'd14,
      ROP_SET           = 4'd15
   } rop_code_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      pos_type               start_column;
      logic                  first_of_word;
      logic                  last_of_word;
      word_type              old_dest_word;
   } req_type;

   typedef struct packed {
      word_type new_dest_word;
      word_type written_mask;
   } rsp_type;

   // Merge controls handed to the raster op unit
   typedef struct packed {
      rop_code_type raster_op;
      logic         plane_enable;
   } merge_ctrl_type;

endpackage

/* design/bit_plane_extract_pack_rop.sv */
// Top level of the bit-plane extract/pack block with raster op merge.
// Depends on bpe_pkg and bpe_rop.
`timescale 1ns / 1ps

// Takes one 8-bit source pixel per transaction, extracts the bit chosen by
// plane_select and packs it at the pixel's column of a 32-bit destination
// word (column c lands on bit 31-c when msb_first is set, bit c otherwise).
// first_of_word restarts the word at start_column; each later pixel moves one
// column on, wrapping from 31 to 0. The transaction with last_of_word merges the
// packed bits into old_dest_word through the configured X raster op under the
// cover mask and returns one response (new word plus mask); other pixels give
// no response. Throughput is one transaction per cycle while no last_of_word
// request waits on a full, unread result register. rsp_valid is registered: the
// last_of_word request passes the request register, then the result register.
// Packing state lives in the stage after the request register, so the only
// thing that holds up the input is a full, unread result register.
// CSR writes are accepted every cycle and must only be issued while idle.
module bit_plane_extract_pack_rop (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  bpe_pkg::req_type                       req_data,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output bpe_pkg::rsp_type                       rsp_data,
   // CSR write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bpe_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [bpe_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   // ---------------- CSRs ----------------
   bpe_pkg::rop_code_type                 raster_op_ff;
   logic [bpe_pkg::PLANE_BITS-1:0]        plane_select_ff;
   logic                                  plane_enable_ff;
   logic                                  msb_first_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raster_op_ff    <= bpe_pkg::ROP_COPY;
         plane_select_ff <= '0;
         plane_enable_ff <= 1'b1;
         msb_first_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpe_pkg::CSR_RASTER_OP:
               raster_op_ff <= bpe_pkg::rop_code_type'(csr_wdata[bpe_pkg::ROP_BITS-1:0]);
            bpe_pkg::CSR_PLANE_SELECT:
               plane_select_ff <= csr_wdata[bpe_pkg::PLANE_BITS-1:0];
            bpe_pkg::CSR_PLANE_ENABLE:
               plane_enable_ff <= csr_wdata[0];
            bpe_pkg::CSR_MSB_FIRST:
               msb_first_ff <= csr_wdata[0];
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   // ---------------- request register ----------------
   logic              s1_valid_ff;
   bpe_pkg::req_type  s1_req_ff;
   logic              s1_advance;
   logic              out_free;

   assign out_free   = !rsp_valid || rsp_ready;
   // a non-last pixel only touches the packing state, never the result register
   assign s1_advance = s1_valid_ff && (!s1_req_ff.last_of_word || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_data;
      end
   end

   // ---------------- packing state ----------------
   bpe_pkg::word_type packed_bits_ff, packed_bits_in;
   bpe_pkg::word_type cover_mask_ff,  cover_mask_in;
   bpe_pkg::pos_type  bit_position_ff, bit_position_in;

   bpe_pkg::word_type base_packed, base_mask, col_bit;
   bpe_pkg::word_type cur_packed, cur_mask;
   bpe_pkg::pos_type  cur_pos, bit_index;
   logic              plane_bit;

   always_comb begin
      // word start discards whatever was gathered
      base_packed = s1_req_ff.first_of_word ? '0 : packed_bits_ff;
      base_mask   = s1_req_ff.first_of_word ? '0 : cover_mask_ff;
      cur_pos     = s1_req_ff.first_of_word ? s1_req_ff.start_column : bit_position_ff;
      // msb-first: column c -> bit (WORD_BITS-1)-c, which is ~c on POS_BITS bits
      bit_index   = msb_first_ff ? ~cur_pos : cur_pos;
      col_bit     = bpe_pkg::word_type'(1) << bit_index;
      plane_bit   = s1_req_ff.pixel[plane_select_ff];
      cur_packed  = (base_packed & ~col_bit) | (plane_bit ? col_bit : '0);
      cur_mask    = base_mask | col_bit;

      if (s1_req_ff.last_of_word) begin
         packed_bits_in  = '0;
         cover_mask_in   = '0;
         bit_position_in = '0;
      end else begin
         packed_bits_in  = cur_packed;
         cover_mask_in   = cur_mask;
         bit_position_in = cur_pos + bpe_pkg::pos_type'(1);  // wraps 31 -> 0
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packed_bits_ff  <= '0;
         cover_mask_ff   <= '0;
         bit_position_ff <= '0;
      end else if (s1_advance) begin
         packed_bits_ff  <= packed_bits_in;
         cover_mask_ff   <= cover_mask_in;
         bit_position_ff <= bit_position_in;
      end
   end

   // ---------------- merge and result register ----------------
   bpe_pkg::merge_ctrl_type merge_ctrl;
   bpe_pkg::word_type       merged_word;
   logic                    rsp_valid_ff;
   bpe_pkg::rsp_type        rsp_data_ff;

   assign merge_ctrl.raster_op    = raster_op_ff;
   assign merge_ctrl.plane_enable = plane_enable_ff;

   bpe_rop u_rop (
      .ctrl   (merge_ctrl),
      .src    (cur_packed),
      .dst    (s1_req_ff.old_dest_word),
      .mask   (cur_mask),
      .merged (merged_word)
   );

   logic load_rsp;
   assign load_rsp = s1_advance && s1_req_ff.last_of_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.new_dest_word <= merged_word;
         rsp_data_ff.written_mask  <= cur_mask;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/bpe_rop.sv */
// Raster op and masked merge of a packed source word into a destination word.
// Depends on bpe_pkg.
`timescale 1ns / 1ps

module bpe_rop (
   input  bpe_pkg::merge_ctrl_type ctrl,
   input  bpe_pkg::word_type       src,
   input  bpe_pkg::word_type       dst,
   input  bpe_pkg::word_type       mask,
   output bpe_pkg::word_type       merged
);

   bpe_pkg::word_type rop_out;

   always_comb begin
      unique case (ctrl.raster_op)
         bpe_pkg::ROP_CLEAR:         rop_out = '0;
         bpe_pkg::ROP_AND:           rop_out = src & dst;
         bpe_pkg::ROP_AND_REVERSE:   rop_out = src & ~dst;
         bpe_pkg::ROP_COPY:          rop_out = src;
         bpe_pkg::ROP_AND_INVERTED:  rop_out = ~src & dst;
         bpe_pkg::ROP_NOOP:          rop_out = dst;
         bpe_pkg::ROP_XOR:           rop_out = src ^ dst;
         bpe_pkg::ROP_OR:            rop_out = src | dst;
         bpe_pkg::ROP_NOR:           rop_out = ~(src | dst);
         bpe_pkg::ROP_EQUIV:         rop_out = ~src ^ dst;
         bpe_pkg::ROP_INVERT:        rop_out = ~dst;
         bpe_pkg::ROP_OR_REVERSE:    rop_out = src | ~dst;
         bpe_pkg::ROP_COPY_INVERTED: rop_out = ~src;
         bpe_pkg::ROP_OR_INVERTED:   rop_out = ~src | dst;
         bpe_pkg::ROP_NAND:          rop_out = ~(src & dst);
         bpe_pkg::ROP_SET:           rop_out = '1;
         default:                    rop_out = '1;
      endcase
   end

   assign merged = ctrl.plane_enable ? ((dst & ~mask) | (rop_out & mask)) : dst;

endmodule
